>>> rtl/assert_macros.svh
// Assertion macros used by radial_warp_source_mapper_top.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> rtl/rwsm_pkg.sv
// Types and constants of the radial warp source mapper.
package rwsm_pkg;
  localparam int CB = 12;                      // coordinate bits
  localparam int FB = CB + 1;                  // frame size bits
  localparam int SW = 2 * FB + 1;              // squared distance bits
  localparam int FRAC = 8;                     // distance fraction bits
  localparam int SQ_STEPS = (SW + 2 * FRAC + 1) / 2;
  localparam int RADW = 2 * SQ_STEPS;
  localparam int D8W = SQ_STEPS;
  localparam int REMW = D8W + 2;
  localparam int QB = 16;                      // ratio fraction bits
  localparam logic [CB-1:0] CMASK = '1;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_TARGET_X = 3'd2;
  localparam logic [2:0] REG_TARGET_Y = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;
  localparam logic [2:0] REG_WIDTH    = 3'd5;
  localparam logic [2:0] REG_HEIGHT   = 3'd6;

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
  } item_t;

  typedef struct packed {
    logic            valid;
    item_t           item;
    logic [REMW-1:0] rem;
    logic [D8W-1:0]  root;
    logic [RADW-1:0] rad;
  } sq_t;

  typedef struct packed {
    logic          valid;
    item_t         item;
    logic          in_disk;
    logic [CB-1:0] rem;
    logic [QB-1:0] num;
    logic [QB-1:0] q;
  } div_t;
endpackage

>>> rtl/radial_warp_source_mapper_top.sv
// Radial warp source mapper: destination pixel in, clamped source pixel out.
// Pipeline from input transfer to output valid: 3 front stages,
//   22 square-root cells, 16 divide cells, multiply stage, output stage.
// Throughput: one pixel per cycle while the output is not stalled; the whole row
//   of cells advances together and a one-entry skid buffer keeps s_tready registered.
// Reset (rst, synchronous): pipeline empty, registers to center 0, target 0,
//   radius 1, frame 640 x 480.
`include "assert_macros.svh"
module radial_warp_source_mapper_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [23:0]             s_tdata,   // pix_x[11:0], pix_y[23:12]
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata,   // src_x, src_y, inside_disk, was_clamped, zero
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [rwsm_pkg::FB-1:0] cfg_data
);
  import rwsm_pkg::*;

  // configuration registers
  logic [CB-1:0] center_x, center_y, target_x, target_y, warp_radius;
  logic [FB-1:0] frame_width, frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      target_x     <= '0;
      target_y     <= '0;
      warp_radius  <= CB'(1);
      frame_width  <= FB'(640);
      frame_height <= FB'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x     <= cfg_data[CB-1:0];
        REG_CENTER_Y: center_y     <= cfg_data[CB-1:0];
        REG_TARGET_X: target_x     <= cfg_data[CB-1:0];
        REG_TARGET_Y: target_y     <= cfg_data[CB-1:0];
        REG_RADIUS:   warp_radius  <= cfg_data[CB-1:0];
        REG_WIDTH:    frame_width  <= cfg_data;
        REG_HEIGHT:   frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived constants; the user must make config changes only while the pipe is empty, the block does not enforce this
  logic [FB-1:0] cyf, tyf, span_y;
  logic [CB-1:0] span_x;
  logic          down_x, down_y;
  logic [FB-1:0] lim_x, lim_y;

  always_comb begin
    cyf    = ({1'b0, center_y} >= frame_height) ? {1'b0, center_y} - frame_height
                                                : frame_height - {1'b0, center_y};
    tyf    = ({1'b0, target_y} >= frame_height) ? {1'b0, target_y} - frame_height
                                                : frame_height - {1'b0, target_y};
    span_y = (tyf >= cyf) ? tyf - cyf : cyf - tyf;
    span_x = (target_x >= center_x) ? target_x - center_x : center_x - target_x;
    down_x = {1'b0, target_x} >= (frame_width >> 1);
    down_y = tyf >= (frame_height >> 1);
    lim_x  = (frame_width == '0) ? '0 : frame_width - FB'(1);
    if (lim_x > {1'b0, CMASK}) lim_x = {1'b0, CMASK};
    lim_y  = (frame_height == '0) ? '0 : frame_height - FB'(1);
    if (lim_y > {1'b0, CMASK}) lim_y = {1'b0, CMASK};
  end

  // output stage and global advance
  logic outv;
  logic adv;
  assign adv = !outv || m_tready;

  // skid buffer on the input side
  logic  skid_v;
  item_t skid_item, in_item;
  logic  in_v;

  assign s_tready = !skid_v;
  assign in_v     = skid_v || s_tvalid;
  assign in_item  = skid_v ? skid_item : item_t'({s_tdata[11:0], s_tdata[23:12]});

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (adv) begin
      skid_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && s_tvalid && s_tready) skid_item <= item_t'({s_tdata[11:0], s_tdata[23:12]});
  end

  // stage A: axis distances
  logic          a_v;
  item_t         a_item;
  logic [CB-1:0] a_ddx;
  logic [FB-1:0] a_ddy;
  // stage B: squares
  logic            b_v;
  item_t           b_item;
  logic [2*CB-1:0] b_sqx;
  logic [2*FB-1:0] b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (adv) begin
      a_v <= in_v;
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= in_item;
      a_ddx  <= (in_item.px >= center_x) ? in_item.px - center_x : center_x - in_item.px;
      a_ddy  <= ({1'b0, in_item.py} >= cyf) ? {1'b0, in_item.py} - cyf
                                            : cyf - {1'b0, in_item.py};
      b_item <= a_item;
      b_sqx  <= a_ddx * a_ddx;
      b_sqy  <= a_ddy * a_ddy;
    end
  end

  // stage C: squared distance into the square-root row
  sq_t           sq [0:SQ_STEPS];
  logic [SW-1:0] sum_sq;
  assign sum_sq = SW'(b_sqx) + SW'(b_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (adv) begin
      sq[0].valid <= b_v;
      sq[0].item  <= b_item;
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
      sq[0].rad   <= RADW'({sum_sq, (2*FRAC)'(0)});
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    rwsm_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  // Q.8 distance into the divide row; inside the disk the partial
  // remainder starts below the radius
  div_t           dv [0:QB];
  logic [D8W-1:0] d8;
  assign d8 = sq[SQ_STEPS].root;

  always_comb begin
    dv[0].valid   = sq[SQ_STEPS].valid;
    dv[0].item    = sq[SQ_STEPS].item;
    dv[0].in_disk = (warp_radius != '0) &&
                    (d8 < D8W'({warp_radius, FRAC'(0)}));
    dv[0].rem     = CB'(d8 >> FRAC);
    dv[0].num     = {d8[FRAC-1:0], (QB-FRAC)'(0)};
    dv[0].q       = '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    rwsm_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .radius (warp_radius),
      .d      (dv[i]),
      .q      (dv[i+1])
    );
  end

  // stage M: factor 1 - r/R (1.0 maps to 0) times the span
  logic             m_v, m_inside;
  item_t            m_item;
  logic [CB+QB-1:0] m_offx;
  logic [FB+QB-1:0] m_offy;
  logic [QB-1:0]    fac;
  assign fac = (dv[QB].q == '0) ? '0 : QB'(0) - dv[QB].q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= dv[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_item   <= dv[QB].item;
      m_inside <= dv[QB].in_disk;
      m_offx   <= span_x * fac;
      m_offy   <= span_y * fac;
    end
  end

  // stage O: shift, absolute value, clamp
  logic [FB+QB:0] basex, basey, offx, offy, magx, magy;
  logic [FB:0]    sx, sy;
  logic           hitx, hity;
  logic [CB-1:0]  src_x, src_y;
  logic           inside_disk, was_clamped;

  always_comb begin
    basex = (FB+QB+1)'({m_item.px, QB'(0)});
    basey = (FB+QB+1)'({m_item.py, QB'(0)});
    offx  = (FB+QB+1)'(m_offx);
    offy  = (FB+QB+1)'(m_offy);
    if (down_x) magx = (basex >= offx) ? basex - offx : offx - basex;
    else        magx = basex + offx;
    if (down_y) magy = (basey >= offy) ? basey - offy : offy - basey;
    else        magy = basey + offy;
    sx = m_inside ? magx[FB+QB:QB] : (FB+1)'(m_item.px);
    sy = m_inside ? magy[FB+QB:QB] : (FB+1)'(m_item.py);
    hitx = sx > {1'b0, lim_x};
    hity = sy > {1'b0, lim_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outv <= 1'b0;
    end else if (adv) begin
      outv <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      src_x       <= hitx ? lim_x[CB-1:0] : sx[CB-1:0];
      src_y       <= hity ? lim_y[CB-1:0] : sy[CB-1:0];
      inside_disk <= m_inside;
      was_clamped <= hitx || hity;
    end
  end

  assign m_tvalid = outv;
  assign m_tdata  = {6'b0, was_clamped, inside_disk, src_y, src_x};

  // skid only fills while a result is stalled
  `ASSERT_IMP(a_skid_out, clk, rst, skid_v, outv)
  `ASSERT_NEXT(a_skid_hold, clk, rst, skid_v && !adv, skid_v)
  `ASSERT_IMP(a_disk_radius, clk, rst, outv && inside_disk, warp_radius != '0)
  `ASSERT_IMP(a_clamp_x, clk, rst, outv && frame_width != '0, {1'b0, src_x} < frame_width)
endmodule

>>> rtl/rwsm_sqrt_cell.sv
// One digit of the square root chain: two radicand bits in, one root bit out.
module rwsm_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  rwsm_pkg::sq_t d,
  output rwsm_pkg::sq_t q
);
  import rwsm_pkg::*;

  logic [REMW+1:0] cat, trial, diff;
  logic            ge;
  sq_t             nxt;

  always_comb begin
    cat   = {d.rem, d.rad[RADW-1 -: 2]};
    trial = (REMW+2)'({d.root, 2'b01});
    ge    = cat >= trial;
    diff  = cat - trial;
    nxt       = d;
    nxt.rad   = d.rad << 2;
    nxt.rem   = ge ? diff[REMW-1:0] : cat[REMW-1:0];
    nxt.root  = {d.root[D8W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end
endmodule

>>> rtl/rwsm_div_cell.sv
// One step of the restoring divide chain: one quotient bit per cell.
module rwsm_div_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [rwsm_pkg::CB-1:0] radius,
  input  rwsm_pkg::div_t         d,
  output rwsm_pkg::div_t         q
);
  import rwsm_pkg::*;

  logic [CB:0] cat, diff;
  logic        ge;
  div_t        nxt;

  always_comb begin
    cat  = {d.rem, d.num[QB-1]};
    ge   = cat >= {1'b0, radius};
    diff = cat - {1'b0, radius};
    nxt      = d;
    nxt.num  = d.num << 1;
    nxt.rem  = ge ? diff[CB-1:0] : cat[CB-1:0];
    nxt.q    = {d.q[QB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end
endmodule

>>> tb/sv/tb_radial_warp_source_mapper_top.sv
// Testbench for the radial warp source mapper: random and directed pixels against a predictor.
module tb_radial_warp_source_mapper_top;
  import rwsm_pkg::*;

  typedef struct {
    logic [11:0] sx;
    logic [11:0] sy;
    logic        in_disk;
    logic        clamped;
  } src_pix_t;

  // Warp settings as the block holds them
  logic [11:0] cx, cy, tx, ty, rad;
  logic [12:0] fw, fh;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] adiff(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [63:0] moved(input logic [63:0] c, input logic [63:0] span,
                                        input logic [63:0] f, input logic dn);
    logic [63:0] base, off;
    base = c << 16;
    off = span * f;
    if (dn) return adiff(base, off) >> 16;
    return (base + off) >> 16;
  endfunction

  function automatic src_pix_t map_pixel(input logic [11:0] px, input logic [11:0] py);
    src_pix_t o;
    logic [63:0] cyf, tyf, dx, dy, d8, q, f, sx, sy, lx, ly;
    cyf = adiff(cy, fh);
    tyf = adiff(ty, fh);
    dx = adiff(px, cx);
    dy = adiff(py, cyf);
    d8 = root64((dx * dx + dy * dy) << 16);
    sx = px;
    sy = py;
    o.in_disk = 0;
    o.clamped = 0;
    if (rad != 0 && d8 < ({52'd0, rad} << 8)) begin
      q = (d8 << 8) / rad;
      f = 64'd65536 - q;
      if (f >= 64'd65536) f = 0;     // factor of 1.0 at the center drops to 0
      o.in_disk = 1;
      sx = moved(px, adiff(tx, cx), f, tx >= (fw >> 1));
      sy = moved(py, adiff(tyf, cyf), f, tyf >= (fh >> 1));
    end
    lx = (fw == 0) ? 0 : fw - 1;
    if (lx > 4095) lx = 4095;
    ly = (fh == 0) ? 0 : fh - 1;
    if (ly > 4095) ly = 4095;
    if (sx > lx) begin sx = lx; o.clamped = 1; end
    if (sy > ly) begin sy = ly; o.clamped = 1; end
    o.sx = sx[11:0];
    o.sy = sy[11:0];
    return o;
  endfunction

  class warp_scoreboard;
    src_pix_t pending[$];
    int errors;

    function void note_pixel(logic [11:0] px, logic [11:0] py);
      pending.push_back(map_pixel(px, py));
    endfunction

    function void check_source(logic [31:0] d);
      src_pix_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[11:0] !== e.sx || d[23:12] !== e.sy || d[24] !== e.in_disk ||
          d[25] !== e.clamped) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp sx=%0d sy=%0d in=%0b cl=%0b got sx=%0d sy=%0d in=%0b cl=%0b",
                   e.sx, e.sy, e.in_disk, e.clamped, d[11:0], d[23:12], d[24], d[25]);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [23:0] s_tdata = 0;
  logic m_tvalid, m_tready = 0;
  logic [31:0] m_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_CENTER_X;
  logic [FB-1:0] cfg_data = 0;

  warp_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_rx = 0;      // long receiver hold-off request

  always #1 clk = ~clk;

  radial_warp_source_mapper_top dut (.*);

  // Sample transfers at the rising edge; watchdog counts cycles with no transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata[11:0], s_tdata[23:12]);
      if (m_tvalid && m_tready) sb.check_source(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 3000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        m_tready <= 0;
        repeat (200) @(negedge clk);
        hold_rx = 0;
      end else begin
        w = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w != 0) begin
          m_tready <= 0;
          repeat (w) @(negedge clk);
        end
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [FB-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CENTER_X: cx = val[11:0];
      REG_CENTER_Y: cy = val[11:0];
      REG_TARGET_X: tx = val[11:0];
      REG_TARGET_Y: ty = val[11:0];
      REG_RADIUS:   rad = val[11:0];
      REG_WIDTH:    fw = val;
      REG_HEIGHT:   fh = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Send one pixel; gap drawn per item unless told to stream
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 8) : 0;
    if (gaps && $urandom_range(0, 3) == 0) w = 0;
    if (w != 0) begin
      s_tvalid <= 0;
      repeat (w) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_send();
    s_tvalid <= 0;
  endtask

  // Random pixel: mostly near the center so the disk is hit often
  task automatic rand_pixel(input bit gaps);
    logic [11:0] px, py, cyf;
    cyf = 12'(adiff(cy, fh));
    if ($urandom_range(0, 3) != 0) begin
      px = 12'(cx + $urandom_range(0, 2 * rad + 2) - rad - 1);
      py = 12'(cyf + $urandom_range(0, 2 * rad + 2) - rad - 1);
    end else begin
      px = 12'($urandom);
      py = 12'($urandom);
    end
    send_pixel(px, py, gaps);
  endtask

  task automatic rand_settings(input logic [11:0] rmax);
    write_reg(REG_WIDTH, 13'($urandom_range(1, 4096)));
    write_reg(REG_HEIGHT, 13'($urandom_range(1, 4096)));
    write_reg(REG_CENTER_X, 13'($urandom));
    write_reg(REG_CENTER_Y, 13'($urandom));
    write_reg(REG_TARGET_X, 13'($urandom));
    write_reg(REG_TARGET_Y, 13'($urandom));
    write_reg(REG_RADIUS, 13'($urandom_range(0, rmax)));
  endtask

  initial begin
    cx = 0; cy = 0; tx = 0; ty = 0; rad = 1; fw = 640; fh = 480;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset settings, center pixel, field extremes
    send_pixel(12'd0, 12'd480, 1);
    send_pixel(12'd0, 12'd0, 1);
    send_pixel(12'hfff, 12'hfff, 1);
    send_pixel(12'h000, 12'hfff, 1);
    send_pixel(12'hfff, 12'h000, 1);
    idle_send();
    drain();

    // Small disk, target past half; then zero radius; then tiny and huge frames
    write_reg(REG_WIDTH, 13'd200);
    write_reg(REG_HEIGHT, 13'd100);
    write_reg(REG_CENTER_X, 12'd50);
    write_reg(REG_CENTER_Y, 12'd40);
    write_reg(REG_TARGET_X, 12'd150);
    write_reg(REG_TARGET_Y, 12'd90);
    write_reg(REG_RADIUS, 12'd20);
    send_pixel(12'd50, 12'd60, 1);   // exact center after vertical flip
    send_pixel(12'd55, 12'd63, 1);
    send_pixel(12'd69, 12'd60, 1);   // just inside the rim
    send_pixel(12'd70, 12'd60, 1);   // on the rim
    send_pixel(12'd300, 12'd300, 1); // outside the frame
    idle_send();
    drain();
    write_reg(REG_RADIUS, 12'd0);
    send_pixel(12'd50, 12'd60, 1);
    send_pixel(12'd3000, 12'd10, 1);
    idle_send();
    drain();
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    write_reg(REG_RADIUS, 12'hfff);
    write_reg(REG_TARGET_X, 12'hfff);
    send_pixel(12'd1, 12'd1, 1);
    send_pixel(12'hfff, 12'hfff, 1);
    idle_send();
    drain();
    write_reg(REG_WIDTH, 13'd4096);
    write_reg(REG_HEIGHT, 13'd4096);
    write_reg(REG_CENTER_X, 12'hfff);
    write_reg(REG_CENTER_Y, 12'hfff);
    write_reg(REG_TARGET_X, 12'd0);
    write_reg(REG_TARGET_Y, 12'hfff);
    send_pixel(12'hfff, 12'd1, 1);
    send_pixel(12'd0, 12'd0, 1);
    send_pixel(12'h800, 12'h7ff, 1);
    idle_send();
    drain();

    // Random phases with changing settings; a long hold-off fills the pipeline
    for (int ph = 0; ph < 13; ph++) begin
      rand_settings(ph % 3 == 0 ? 12'hfff : 12'd64);
      if (ph == 2) hold_rx = 1;
      for (int i = 0; i < 100; i++) rand_pixel(ph != 2 && (ph % 4 != 3 || i > 50));
      idle_send();
      drain();   // sender pauses until every result is back
    end

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
